// ===== sv/gsdn_pkg.sv =====
// ----------------------------------------------------------------------------
// gsdn_pkg
// Shared types, codes and helpers of the grid store with disk neighbourhood
// scan.
// ----------------------------------------------------------------------------
package gsdn_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam logic [2:0]  MaxRadius    = 3'd4;

  localparam int unsigned CfgDimW = 9;
  localparam logic [CfgDimW-1:0] GridWidthRst   = 9'd256;
  localparam logic [CfgDimW-1:0] GridHeightRst  = 9'd256;
  localparam logic [15:0]        BarrierCodeRst = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_VISIT = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_GRID_HEIGHT  = 2'd1,
    CFG_BARRIER_CODE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_READ_DATA,
    ST_SCAN,
    ST_SCAN_DATA,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] value;
    logic        in_bounds;
    logic        is_empty;
    logic        is_barrier;
    logic        is_occupied;
    logic        last;
  } res_t;

  function automatic res_t make_res(logic [15:0] x, logic [15:0] y, logic ok,
                                    logic [15:0] v, logic [15:0] bc, logic last);
    res_t r;
    r.x           = x;
    r.y           = y;
    r.value       = ok ? v : 16'd0;
    r.in_bounds   = ok;
    r.is_empty    = ok && (v == 16'd0);
    r.is_barrier  = ok && (v == bc);
    r.is_occupied = ok && (v != 16'd0) && (v != bc);
    r.last        = last;
    return r;
  endfunction

endpackage

// ===== sv/gsdn_ram.sv =====
// ----------------------------------------------------------------------------
// gsdn_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module gsdn_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/grid_store_disk_neighborhood.sv =====
// ----------------------------------------------------------------------------
// grid_store_disk_neighborhood
// Row-major grid of 16-bit cells in one RAM, with write, read, clear and a
// scan of a disk neighbourhood around a centre.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  in      | input     | in_valid_i/in_ready_o  | mode, pos_x, pos_y, value, radius
//  out     | output    | out_valid_o/out_ready_i| out_x .. last
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  A write passes through ST_WRITE and a read through ST_READ and then
//  ST_READ_DATA, as the single RAM port gives. A visit steps one offset a
//  cycle over the (2r+1)^2 window, plus a RAM read for each kept cell. A
//  clear, and the pass after reset, sweeps all MAX_WIDTH * MAX_HEIGHT
//  cells of the RAM, with no input taken. A stalled output holds the scan;
//  the next input transfer can be taken while the final result still waits.
// ----------------------------------------------------------------------------
module grid_store_disk_neighborhood #(
  parameter int unsigned MAX_WIDTH  = gsdn_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = gsdn_pkg::DefMaxHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [15:0]        value_i,
  input  logic [2:0]         radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic [15:0]        cell_value_o,
  output logic               in_bounds_o,
  output logic               is_empty_o,
  output logic               is_barrier_o,
  output logic               is_occupied_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import gsdn_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  state_e               state_q, state_d;
  logic [CfgDimW-1:0]   grid_width_q, grid_height_q;
  logic [15:0]          barrier_code_q;
  logic signed [15:0]   px_q, px_d, py_q, py_d;
  logic [15:0]          val_q, val_d;
  logic [2:0]           rad_q, rad_d;
  logic signed [3:0]    dx_q, dx_d, dy_q, dy_d;
  logic                 ok_q, ok_d;
  logic                 pend_valid_q, pend_valid_d;
  res_t                 pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 out_q, out_d;
  logic [AW-1:0]        clr_cnt_q, clr_cnt_d;

  logic [WW-1:0]        wa;
  logic [HW-1:0]        ha;
  logic [16:0]          cur_x, cur_y;
  logic                 cur_in;
  logic [YW+WW-1:0]     prod;
  logic [AW-1:0]        cell_addr;
  logic [3:0]           ax, ay;
  logic [5:0]           dist_sq, rad_sq;
  logic                 in_disk;
  logic signed [3:0]    rs;
  logic                 off_final;
  logic                 out_free;
  logic [2:0]           rad_in;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_addr;
  logic [15:0]          ram_wdata, ram_rdata;

  // Active geometry: zero counts as one, larger values saturate.
  assign wa = (grid_width_q == '0) ? WW'(1) :
              ((32'(grid_width_q) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(grid_width_q));
  assign ha = (grid_height_q == '0) ? HW'(1) :
              ((32'(grid_height_q) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(grid_height_q));

  // Offsets rest at zero outside a scan, so this is the plain position then.
  assign cur_x = {px_q[15], px_q} + {{13{dx_q[3]}}, dx_q};
  assign cur_y = {py_q[15], py_q} + {{13{dy_q[3]}}, dy_q};
  assign cur_in = !cur_x[16] && !cur_y[16] &&
                  (cur_x[15:0] < 16'(wa)) && (cur_y[15:0] < 16'(ha));
  assign prod      = cur_y[YW-1:0] * wa;
  assign cell_addr = AW'(prod) + AW'(cur_x[XW-1:0]);

  assign ax      = dx_q[3] ? 4'(-dx_q) : dx_q;
  assign ay      = dy_q[3] ? 4'(-dy_q) : dy_q;
  assign dist_sq = {3'b0, ax[2:0]} * {3'b0, ax[2:0]} + {3'b0, ay[2:0]} * {3'b0, ay[2:0]};
  assign rad_sq  = {3'b0, rad_q} * {3'b0, rad_q};
  assign in_disk = dist_sq <= rad_sq;
  assign rs        = $signed({1'b0, rad_q});
  assign off_final = (dx_q == rs) && (dy_q == rs);

  assign out_free = !out_valid_q || out_ready_i;
  assign rad_in   = (radius_i > MaxRadius) ? MaxRadius : radius_i;

  always_comb begin
    state_d      = state_q;
    px_d         = px_q;
    py_d         = py_q;
    val_d        = val_q;
    rad_d        = rad_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    ok_d         = ok_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    clr_cnt_d    = clr_cnt_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = cell_addr;
    ram_wdata    = val_q;
    in_ready_o   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = 16'd0;
        if (clr_cnt_q == AW'(Depth - 1)) begin
          clr_cnt_d = '0;
          state_d   = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          px_d  = pos_x_i;
          py_d  = pos_y_i;
          val_d = value_i;
          rad_d = rad_in;
          unique case (mode_e'(mode_i))
            MODE_WRITE: state_d = ST_WRITE;
            MODE_READ:  state_d = ST_READ;
            MODE_VISIT: begin
              dx_d    = 4'(-$signed({1'b0, rad_in}));
              dy_d    = 4'(-$signed({1'b0, rad_in}));
              state_d = ST_SCAN;
            end
            MODE_CLEAR: begin
              clr_cnt_d = '0;
              state_d   = ST_CLEAR;
            end
          endcase
        end
      end
      ST_WRITE: begin
        ram_we  = cur_in;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        ram_re  = cur_in;
        ok_d    = cur_in;
        state_d = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = make_res(px_q, py_q, ok_q, ram_rdata, barrier_code_q, 1'b1);
          state_d     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (in_disk && cur_in) begin
          ram_re  = 1'b1;
          state_d = ST_SCAN_DATA;
        end else if (off_final) begin
          dx_d    = '0;
          dy_d    = '0;
          state_d = ST_FLUSH;
        end else if (dx_q == rs) begin
          dx_d = -rs;
          dy_d = dy_q + 4'sd1;
        end else begin
          dx_d = dx_q + 4'sd1;
        end
      end
      ST_SCAN_DATA: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
          end
          pend_valid_d = 1'b1;
          pend_d       = make_res(cur_x[15:0], cur_y[15:0], 1'b1, ram_rdata,
                                  barrier_code_q, 1'b0);
          if (off_final) begin
            dx_d    = '0;
            dy_d    = '0;
            state_d = ST_FLUSH;
          end else begin
            if (dx_q == rs) begin
              dx_d = -rs;
              dy_d = dy_q + 4'sd1;
            end else begin
              dx_d = dx_q + 4'sd1;
            end
            state_d = ST_SCAN;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      dx_q           <= '0;
      dy_q           <= '0;
      pend_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
      clr_cnt_q      <= '0;
      grid_width_q   <= GridWidthRst;
      grid_height_q  <= GridHeightRst;
      barrier_code_q <= BarrierCodeRst;
    end else begin
      state_q      <= state_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      clr_cnt_q    <= clr_cnt_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GRID_WIDTH:   grid_width_q   <= cfg_data_i[CfgDimW-1:0];
          CFG_GRID_HEIGHT:  grid_height_q  <= cfg_data_i[CfgDimW-1:0];
          CFG_BARRIER_CODE: barrier_code_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    val_q  <= val_d;
    rad_q  <= rad_d;
    ok_q   <= ok_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  gsdn_ram #(
    .Width (16),
    .Depth (Depth)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_q.x;
  assign out_y_o       = out_q.y;
  assign cell_value_o  = out_q.value;
  assign in_bounds_o   = out_q.in_bounds;
  assign is_empty_o    = out_q.is_empty;
  assign is_barrier_o  = out_q.is_barrier;
  assign is_occupied_o = out_q.is_occupied;
  assign last_o        = out_q.last;

  a_ram_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("RAM written and read in the same cycle");

  a_offsets_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (dx_q == 4'sd0 && dy_q == 4'sd0 && !pend_valid_q))
    else $error("Scan state left behind after a visit");

  a_offsets_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_SCAN_DATA) |->
      (dx_q <= rs && dx_q >= -rs && dy_q <= rs && dy_q >= -rs))
    else $error("Scan offset outside the radius window");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_q))
    else $error("Pending result overwritten before its transfer");

endmodule
